// ===== rtl/core/ssfl_pkg.sv =====
package ssfl_pkg;

   // field widths
   localparam int ADDR_W        = 32;
   localparam int SIZE_W        = 16;
   localparam int COUNT_W       = 9;
   localparam int OFFS_W        = COUNT_W + SIZE_W;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 32;

   // parameter defaults
   localparam int MAX_SLOTS_DEF = 256;
   localparam int ADDR_BITS_DEF = 32;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_ADDRESS = 2'd0,
      CSR_SLOT_SIZE    = 2'd1,
      CSR_SLOT_COUNT   = 2'd2
   } ssfl_csr_type;

   // request operation codes
   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } ssfl_op_type;

   typedef struct packed {
      logic              operation;
      logic [ADDR_W-1:0] address;
   } ssfl_req_type;

   typedef struct packed {
      logic               ok;
      logic [ADDR_W-1:0]  slot_address;
      logic [COUNT_W-1:0] occupied;
   } ssfl_rsp_type;

   // divider handshake
   typedef struct packed {
      logic              start;
      logic [OFFS_W-1:0] dividend;
      logic [SIZE_W-1:0] divisor;
   } ssfl_div_req_type;

   typedef struct packed {
      logic               done;
      logic [COUNT_W-1:0] quotient;
   } ssfl_div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_MUL,
      ST_ADD,
      ST_CHECK,
      ST_RANGE,
      ST_DIV
   } ssfl_state_type;

endpackage

// ===== rtl/core/ssfl_link_ram.sv =====
module ssfl_link_ram #(
   parameter int DEPTH = 256,
   parameter int IDX_W = 8
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [IDX_W:0]   wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [IDX_W:0]   rd_data
);

   // each word: fresh-region flag over the next slot index
   logic [IDX_W:0] link_mem_ff [DEPTH];
   logic [IDX_W:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= link_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/ssfl_divider.sv =====
module ssfl_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  ssfl_pkg::ssfl_div_req_type div_req,
   output ssfl_pkg::ssfl_div_rsp_type div_rsp
);

   import ssfl_pkg::*;

   localparam int STEP_W = $clog2(COUNT_W + 1);

   logic               busy_ff,  busy_in;
   logic               done_ff,  done_in;
   logic [OFFS_W-1:0]  rem_ff,   rem_in;
   logic [OFFS_W-1:0]  den_ff,   den_in;
   logic [COUNT_W-1:0] quot_ff,  quot_in;
   logic [STEP_W-1:0]  step_ff,  step_in;
   logic               fits;

   // restoring division, one quotient bit per cycle, msb first
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      fits    = (rem_ff >= den_ff);
      if (div_req.start) begin
         busy_in = 1'b1;
         rem_in  = div_req.dividend;
         den_in  = OFFS_W'(div_req.divisor) << (COUNT_W - 1);
         quot_in = '0;
         step_in = STEP_W'(COUNT_W);
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - den_ff;
         end
         quot_in = {quot_ff[COUNT_W-2:0], fits};
         den_in  = den_ff >> 1;
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

endmodule

// ===== rtl/core/slab_slot_free_list_core.sv =====
// Free-slot manager for one slab of equal-sized slots, kept as a LIFO list with
// the links in a one-port-write, one-port-read memory. Raise start with a request
// while busy is low; it is taken at that edge. Exactly one response beat follows,
// shown on rsp_data for one cycle with rsp_valid high, and it cannot be stalled.
// An allocate that finds no free slot answers from idle, one from the untouched
// fresh region via the multiply and add states, one that pops a freed slot after
// a link memory read too. A free outside the slab answers after the range check;
// one inside it waits for the 9-step divider that turns the offset into a slot
// index. busy drops in the cycle the response is shown, so the next request may
// enter then. A register write resets the list to all slots free in ascending
// order; write registers only while busy is low. No clearing pass is needed
// after reset: link words are always written by a free before they are read.
module slab_slot_free_list_core #(
   parameter int MAX_SLOTS = ssfl_pkg::MAX_SLOTS_DEF,
   parameter int ADDR_BITS = ssfl_pkg::ADDR_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  ssfl_pkg::ssfl_req_type          req_data,
   output logic                            rsp_valid,
   output ssfl_pkg::ssfl_rsp_type          rsp_data,
   input  logic                            csr_write_en,
   input  logic [ssfl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ssfl_pkg::CSR_DATA_W-1:0] csr_write_data
);

   import ssfl_pkg::*;

   localparam int SW = $clog2(MAX_SLOTS);
   localparam int MW = (SW > COUNT_W) ? SW : COUNT_W;
   localparam int PW = MW + SIZE_W;
   localparam int AW = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
   localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - AW);

   ssfl_state_type     state_ff,     state_in;
   logic [ADDR_W-1:0]  base_ff,      base_in;
   logic [SIZE_W-1:0]  size_ff,      size_in;
   logic [COUNT_W-1:0] count_ff,     count_in;
   logic [SW-1:0]      head_ff,      head_in;
   logic               on_stack_ff,  on_stack_in;
   logic [COUNT_W-1:0] water_ff,     water_in;
   logic [COUNT_W-1:0] occ_ff,       occ_in;
   logic [ADDR_W-1:0]  addr_ff,      addr_in;
   logic [SW-1:0]      slot_ff,      slot_in;
   logic [PW-1:0]      prod_ff,      prod_in;
   logic [ADDR_W-1:0]  offset_ff,    offset_in;
   logic               below_ff,     below_in;
   logic               rsp_valid_ff, rsp_valid_in;
   ssfl_rsp_type       rsp_ff,       rsp_in;

   logic               accept;
   logic [COUNT_W-1:0] eff_count;
   logic [MW-1:0]      mul_a;
   logic [ADDR_W-1:0]  sum;
   logic               in_range;
   logic [COUNT_W-1:0] occ_inc;
   logic [COUNT_W-1:0] occ_dec;
   logic               clear_list;

   logic               ram_wr_en;
   logic [SW:0]        ram_wr_data;
   logic               ram_rd_en;
   logic [SW:0]        ram_rd_data;

   ssfl_div_req_type   div_req;
   ssfl_div_rsp_type   div_rsp;

   ssfl_link_ram #(
      .DEPTH (MAX_SLOTS),
      .IDX_W (SW)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_in),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   ssfl_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // slot count clamped to the memory depth
   always_comb begin
      if (int'(count_ff) > MAX_SLOTS) begin
         eff_count = COUNT_W'(MAX_SLOTS);
      end else begin
         eff_count = count_ff;
      end
   end

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // shared multiplier: slot * size on allocate, count * size on free
   assign mul_a   = (state_ff == ST_MUL) ? MW'(slot_ff) : MW'(eff_count);
   assign sum     = (base_ff + ADDR_W'(prod_ff)) & ADDR_MASK;
   assign in_range = (size_ff != '0) && !below_ff &&
                     ((ADDR_W + 1)'(offset_ff) < (ADDR_W + 1)'(prod_ff));

   // saturating occupancy
   assign occ_inc = (&occ_ff) ? occ_ff : occ_ff + 1'b1;
   assign occ_dec = (occ_ff == '0) ? occ_ff : occ_ff - 1'b1;

   // divider gets the in-slab offset
   assign div_req.start    = (state_ff == ST_RANGE) && in_range;
   assign div_req.dividend = OFFS_W'(offset_ff);
   assign div_req.divisor  = size_ff;

   // push word: fresh flag when the list had only the fresh region
   assign ram_wr_data = {!on_stack_ff, head_ff};
   assign ram_rd_en   = accept && (req_data.operation == OP_ALLOC) && on_stack_ff;

   // next state and datapath
   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      size_in      = size_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      on_stack_in  = on_stack_ff;
      water_in     = water_ff;
      occ_in       = occ_ff;
      addr_in      = addr_ff;
      slot_in      = slot_ff;
      prod_in      = prod_ff;
      offset_in    = offset_ff;
      below_in     = below_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      clear_list   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               addr_in = req_data.address & ADDR_MASK;
               if (req_data.operation == OP_FREE) begin
                  state_in = ST_CHECK;
               end else if (on_stack_ff) begin
                  state_in = ST_POP;
               end else if (water_ff < eff_count) begin
                  slot_in  = SW'(water_ff);
                  water_in = water_ff + 1'b1;
                  state_in = ST_MUL;
               end else begin
                  // list exhausted
                  rsp_valid_in        = 1'b1;
                  rsp_in.ok           = 1'b0;
                  rsp_in.slot_address = '0;
                  rsp_in.occupied     = occ_ff;
               end
            end
         end
         ST_POP: begin
            // link word arrives; unlink the head
            slot_in = head_ff;
            if (ram_rd_data[SW]) begin
               on_stack_in = 1'b0;
            end else begin
               head_in = ram_rd_data[SW-1:0];
            end
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = PW'(mul_a) * PW'(size_ff);
            state_in = ST_ADD;
         end
         ST_ADD: begin
            occ_in              = occ_inc;
            rsp_valid_in        = 1'b1;
            rsp_in.ok           = 1'b1;
            rsp_in.slot_address = sum;
            rsp_in.occupied     = occ_inc;
            state_in            = ST_IDLE;
         end
         ST_CHECK: begin
            prod_in               = PW'(mul_a) * PW'(size_ff);
            {below_in, offset_in} = {1'b0, addr_ff} - {1'b0, base_ff};
            state_in              = ST_RANGE;
         end
         ST_RANGE: begin
            if (in_range) begin
               state_in = ST_DIV;
            end else begin
               rsp_valid_in        = 1'b1;
               rsp_in.ok           = 1'b0;
               rsp_in.slot_address = '0;
               rsp_in.occupied     = occ_ff;
               state_in            = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               // push the freed slot on the head
               slot_in             = SW'(div_rsp.quotient);
               ram_wr_en           = 1'b1;
               head_in             = SW'(div_rsp.quotient);
               on_stack_in         = 1'b1;
               occ_in              = occ_dec;
               rsp_valid_in        = 1'b1;
               rsp_in.ok           = 1'b1;
               rsp_in.slot_address = '0;
               rsp_in.occupied     = occ_dec;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // register writes, each resets the list
      if (csr_write_en) begin
         case (csr_index)
            CSR_BASE_ADDRESS: begin
               base_in    = csr_write_data[ADDR_W-1:0];
               clear_list = 1'b1;
            end
            CSR_SLOT_SIZE: begin
               size_in    = csr_write_data[SIZE_W-1:0];
               clear_list = 1'b1;
            end
            CSR_SLOT_COUNT: begin
               count_in   = csr_write_data[COUNT_W-1:0];
               clear_list = 1'b1;
            end
            default: begin
               clear_list = 1'b0;
            end
         endcase
      end
      if (clear_list) begin
         head_in     = '0;
         on_stack_in = 1'b0;
         water_in    = '0;
         occ_in      = '0;
      end
   end

   // control and list state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= '0;
         size_ff      <= SIZE_W'(64);
         count_ff     <= COUNT_W'(256);
         head_ff      <= '0;
         on_stack_ff  <= 1'b0;
         water_ff     <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         size_ff      <= size_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         on_stack_ff  <= on_stack_in;
         water_ff     <= water_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      slot_ff   <= slot_in;
      prod_ff   <= prod_in;
      offset_ff <= offset_in;
      below_ff  <= below_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== bench/ssfl_checker.sv =====
`timescale 1ns / 1ps

module ssfl_checker
   import ssfl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  ssfl_req_type          req_data,
   input  logic                  rsp_valid,
   input  ssfl_rsp_type          rsp_data,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output int                    fail_count,
   output int                    pending,
   output int                    answered
);

   localparam int SLOTS = MAX_SLOTS_DEF;

   // shadow of the slab: links of pushed slots, head and fresh watermark
   logic [7:0]         link_next [SLOTS];
   logic               link_fresh [SLOTS];
   logic [7:0]         head_slot;
   logic               head_stacked;
   logic [COUNT_W-1:0] watermark;
   logic [COUNT_W-1:0] occupied_slots;

   // shadow of the registers
   logic [ADDR_W-1:0]  base_addr;
   logic [SIZE_W-1:0]  slot_bytes;
   logic [COUNT_W-1:0] slot_total;

   ssfl_rsp_type       answers_due [$];
   ssfl_rsp_type       oldest;

   initial begin
      fail_count = 0;
      pending    = 0;
      answered   = 0;
   end

   // all slots free again, in ascending order
   function automatic void empty_slab();
      head_slot      = '0;
      head_stacked   = 1'b0;
      watermark      = '0;
      occupied_slots = '0;
   endfunction

   // work out the answer to one request and move the slab state along
   function automatic ssfl_rsp_type serve_request(ssfl_req_type req);
      ssfl_rsp_type       ans;
      logic [COUNT_W-1:0] usable;
      logic [7:0]         slot;
      logic [63:0]        offset;
      logic [63:0]        span;
      ans    = '0;
      usable = (slot_total > COUNT_W'(SLOTS)) ? COUNT_W'(SLOTS) : slot_total;
      if (req.operation == OP_ALLOC) begin
         if (head_stacked || watermark < usable) begin
            if (head_stacked) begin
               // pop a freed slot
               slot = head_slot;
               if (link_fresh[slot])
                  head_stacked = 1'b0;
               else
                  head_slot = link_next[slot];
            end else begin
               // take the lowest untouched slot
               slot      = watermark[7:0];
               watermark = watermark + 1'b1;
            end
            ans.ok           = 1'b1;
            ans.slot_address = base_addr + ADDR_W'(slot) * ADDR_W'(slot_bytes);
            if (occupied_slots != '1)
               occupied_slots = occupied_slots + 1'b1;
         end
      end else begin
         span   = 64'(usable) * 64'(slot_bytes);
         offset = 64'(req.address) - 64'(base_addr);
         if (slot_bytes != 0 && req.address >= base_addr && offset < span) begin
            slot = 8'(offset / 64'(slot_bytes));
            if (head_stacked) begin
               link_next[slot]  = head_slot;
               link_fresh[slot] = 1'b0;
            end else begin
               link_fresh[slot] = 1'b1;
            end
            head_slot    = slot;
            head_stacked = 1'b1;
            if (occupied_slots != 0)
               occupied_slots = occupied_slots - 1'b1;
            ans.ok = 1'b1;
         end
      end
      ans.occupied = occupied_slots;
      return ans;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         base_addr  = '0;
         slot_bytes = SIZE_W'(64);
         slot_total = COUNT_W'(256);
         empty_slab();
         answers_due.delete();
      end else begin
         // response beat against the oldest outstanding answer
         if (rsp_valid) begin
            if (answers_due.size() == 0) begin
               $error("rsp beat with no request outstanding: ok %0d addr %h occupied %0d",
                      rsp_data.ok, rsp_data.slot_address, rsp_data.occupied);
               fail_count++;
            end else begin
               oldest = answers_due.pop_front();
               answered++;
               if (rsp_data.ok !== oldest.ok) begin
                  $error("ok: expected %0d, got %0d", oldest.ok, rsp_data.ok);
                  fail_count++;
               end
               if (rsp_data.slot_address !== oldest.slot_address) begin
                  $error("slot_address: expected %h, got %h",
                         oldest.slot_address, rsp_data.slot_address);
                  fail_count++;
               end
               if (rsp_data.occupied !== oldest.occupied) begin
                  $error("occupied: expected %0d, got %0d",
                         oldest.occupied, rsp_data.occupied);
                  fail_count++;
               end
            end
         end
         // register write: store and rebuild the list
         if (csr_write_en) begin
            case (csr_index)
               CSR_BASE_ADDRESS: begin
                  base_addr = csr_write_data[ADDR_W-1:0];
                  empty_slab();
               end
               CSR_SLOT_SIZE: begin
                  slot_bytes = csr_write_data[SIZE_W-1:0];
                  empty_slab();
               end
               CSR_SLOT_COUNT: begin
                  slot_total = csr_write_data[COUNT_W-1:0];
                  empty_slab();
               end
               default: ;
            endcase
         end
         // request beat taken
         if (start && !busy)
            answers_due.push_back(serve_request(req_data));
      end
      pending = answers_due.size();
   end

endmodule

// ===== bench/tb_slab_slot_free_list_core.sv =====
`timescale 1ns / 1ps

module tb_slab_slot_free_list_core;
   import ssfl_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   ssfl_req_type          req_data;
   logic                  rsp_valid;
   ssfl_rsp_type          rsp_data;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   int fail_count;
   int pending;
   int answered;

   // register values as last written, for building addresses
   logic [ADDR_W-1:0]  cfg_base;
   logic [SIZE_W-1:0]  cfg_size;
   logic [COUNT_W-1:0] cfg_count;

   int burst_left;
   int gap;
   int items_sent;
   int settings;
   int allocs_in_phase;
   int alloc_pct;
   int phase_items;
   int pause_at;
   int roll;
   int usable;
   int pick_limit;
   logic [63:0]        full_addr;
   logic [ADDR_W-1:0]  new_base;
   logic [SIZE_W-1:0]  new_size;
   logic [COUNT_W-1:0] new_count;

   slab_slot_free_list_core dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   ssfl_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .fail_count     (fail_count),
      .pending        (pending),
      .answered       (answered)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // hard stop in case the block hangs
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // one request beat, inside random bursts
   task automatic send_request(input ssfl_op_type op, input logic [ADDR_W-1:0] addr);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      start              = 1'b1;
      req_data.operation = op;
      req_data.address   = addr;
      do @(posedge clock); while (busy);
      items_sent++;
      burst_left--;
      if (op == OP_ALLOC)
         allocs_in_phase++;
      @(negedge clock);
   endtask

   // stop sending and let every outstanding answer come back
   task automatic drain();
      start = 1'b0;
      do @(negedge clock); while (pending != 0 || busy);
   endtask

   // write the chosen registers back to back while the block is idle
   task automatic program_slab(input bit wr_base, input bit wr_size, input bit wr_count,
                               input logic [ADDR_W-1:0] base,
                               input logic [SIZE_W-1:0] size,
                               input logic [COUNT_W-1:0] count);
      drain();
      if (wr_base) begin
         csr_write_en   = 1'b1;
         csr_index      = CSR_BASE_ADDRESS;
         csr_write_data = CSR_DATA_W'(base);
         cfg_base       = base;
         @(negedge clock);
      end
      if (wr_size) begin
         csr_write_en   = 1'b1;
         csr_index      = CSR_SLOT_SIZE;
         csr_write_data = CSR_DATA_W'(size);
         cfg_size       = size;
         @(negedge clock);
      end
      if (wr_count) begin
         csr_write_en   = 1'b1;
         csr_index      = CSR_SLOT_COUNT;
         csr_write_data = CSR_DATA_W'(count);
         cfg_count      = count;
         @(negedge clock);
      end
      csr_write_en    = 1'b0;
      allocs_in_phase = 0;
      settings++;
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_data       = '0;
      csr_write_en   = 1'b0;
      csr_index      = CSR_BASE_ADDRESS;
      csr_write_data = '0;
      cfg_base       = '0;
      cfg_size       = SIZE_W'(64);
      cfg_count      = COUNT_W'(256);
      burst_left      = 0;
      items_sent      = 0;
      settings        = 1;
      allocs_in_phase = 0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // reset settings: free on an empty slab, pops, inside-slot free,
      // range edges, double free
      send_request(OP_FREE, 32'h0000_0000);
      send_request(OP_ALLOC, 32'hFFFF_FFFF);
      send_request(OP_ALLOC, 32'h0000_0000);
      send_request(OP_ALLOC, 32'hA5A5_5A5A);
      send_request(OP_ALLOC, 32'h5A5A_A5A5);
      send_request(OP_FREE, 32'd64 + 32'd37);
      send_request(OP_FREE, 32'd16384);
      send_request(OP_FREE, 32'd16383);
      send_request(OP_FREE, 32'hFFFF_FFFF);
      send_request(OP_ALLOC, 32'h0);
      send_request(OP_ALLOC, 32'h0);
      send_request(OP_FREE, 32'd128);
      send_request(OP_FREE, 32'd128);
      send_request(OP_ALLOC, 32'h0);
      send_request(OP_ALLOC, 32'h0);

      // single slot: one allocate then the list runs dry
      program_slab(0, 0, 1, '0, '0, COUNT_W'(1));
      send_request(OP_ALLOC, 32'h0);
      send_request(OP_ALLOC, 32'h0);
      send_request(OP_FREE, 32'd63);

      // no slots at all
      program_slab(0, 0, 1, '0, '0, COUNT_W'(0));
      send_request(OP_ALLOC, 32'h0);
      send_request(OP_FREE, 32'h0);

      // zero slot size: frees fail, allocates answer the base
      program_slab(1, 1, 1, 32'h0000_1000, SIZE_W'(0), COUNT_W'(3));
      send_request(OP_FREE, 32'h0000_1000);
      send_request(OP_ALLOC, 32'h0);

      // top of the address space with the largest slots and a clamped count
      program_slab(1, 1, 1, 32'hFFFF_FF00, 16'hFFFF, COUNT_W'(511));
      send_request(OP_ALLOC, 32'h0);
      send_request(OP_ALLOC, 32'h0);
      send_request(OP_FREE, 32'hFFFF_FFFF);
      send_request(OP_FREE, 32'h0000_0010);

      // random settings, each with a mix of allocates and frees
      repeat (10) begin
         case ($urandom_range(0, 3))
            0:       new_base = '0;
            1:       new_base = 32'hFFFF_FFFF - $urandom_range(0, 4095);
            default: new_base = $urandom;
         endcase
         case ($urandom_range(0, 4))
            0:       new_size = SIZE_W'(1);
            1:       new_size = 16'hFFFF;
            2:       new_size = SIZE_W'($urandom_range(1, 300));
            default: new_size = SIZE_W'($urandom_range(1, 65535));
         endcase
         case ($urandom_range(0, 7))
            0:       new_count = COUNT_W'(1);
            1, 2:    new_count = COUNT_W'($urandom_range(2, 8));
            3, 4:    new_count = COUNT_W'($urandom_range(2, 32));
            5:       new_count = COUNT_W'(256);
            6:       new_count = COUNT_W'($urandom_range(257, 511));
            default: new_count = COUNT_W'($urandom_range(33, 255));
         endcase
         program_slab(1, 1, 1, new_base, new_size, new_count);
         usable      = (cfg_count > 256) ? 256 : int'(cfg_count);
         alloc_pct   = $urandom_range(35, 70);
         phase_items = $urandom_range(35, 50);
         pause_at    = $urandom_range(5, phase_items - 5);
         for (int n = 0; n < phase_items; n++) begin
            if (n == pause_at)
               drain();
            roll = $urandom_range(0, 99);
            if (roll < alloc_pct) begin
               send_request(OP_ALLOC, $urandom);
            end else if (roll < 88 && usable > 0) begin
               // free somewhere inside a slot that was likely handed out
               pick_limit = (allocs_in_phase < usable) ? allocs_in_phase : usable;
               full_addr  = 64'(cfg_base)
                          + 64'($urandom_range(0, (pick_limit > 0) ? pick_limit - 1 : 0))
                            * 64'(cfg_size);
               if (cfg_size != 0 && $urandom_range(0, 1))
                  full_addr = full_addr + 64'($urandom_range(0, int'(cfg_size) - 1));
               send_request(OP_FREE, full_addr[ADDR_W-1:0]);
            end else begin
               // stray frees: anywhere, just below the slab, just past it
               case ($urandom_range(0, 2))
                  0:       full_addr = 64'($urandom);
                  1:       full_addr = 64'(cfg_base) - 64'd1;
                  default: full_addr = 64'(cfg_base) + 64'(usable) * 64'(cfg_size);
               endcase
               send_request(OP_FREE, full_addr[ADDR_W-1:0]);
            end
         end
      end

      // wind down and give the verdict
      drain();
      repeat (20) @(posedge clock);
      $display("covered %0d requests over %0d register settings, %0d responses checked",
               items_sent, settings, answered);
      if (fail_count == 0 && pending == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
